// ----- hw/rtl/rrts_pkg.sv -----
// Shared types, sizes and codes for the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS      = 8;
    localparam int NUM_SEMAPHORES = 8;

    localparam int TID_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SEM_W     = $clog2(NUM_SEMAPHORES + 1);
    localparam int SEM_IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int DLY_W     = 15;
    localparam int MS_W      = 16;
    localparam int SID_W     = 3;

    localparam logic [SEM_W-1:0] SEM_NONE = SEM_W'(NUM_SEMAPHORES);

    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_FULL  = 2'd1;
    localparam logic [1:0] RS_RANGE = 2'd2;

    localparam logic [MS_W-1:0] MIN_DELAY_RESET = 16'd2;
    localparam logic [MS_W-1:0] MAX_DELAY_RESET = 16'd60000;

    typedef enum logic [1:0] {
        REG_MIN_DELAY = 2'd0,
        REG_MAX_DELAY = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TS_EMPTY   = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_BLOCKED = 2'd3
    } task_st_t;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_CREATE = 3'd1,
        K_DELAY  = 3'd2,
        K_WAIT   = 3'd3,
        K_SIGNAL = 3'd4,
        K_SET    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_TICK   = 3'd1,
        OP_CREATE = 3'd2,
        OP_DELAY  = 3'd3,
        OP_WAIT   = 3'd4,
        OP_SIGNAL = 3'd5,
        OP_PICK   = 3'd6
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [TID_W-1:0] tid;
        logic [TID_W-1:0] cur;
        logic             cur_valid;
        logic [CNT_W-1:0] count;
        logic [DLY_W-1:0] dly;
        logic [SEM_W-1:0] sem;
        logic             found_a;
        logic             any_rdy;
    } cell_cmd_t;

    typedef struct packed {
        task_st_t st;
        logic     hit;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/round_robin_task_scheduler_unit.sv -----
// Top level of the round-robin task scheduler: sequencer, semaphores, task cell chain.
//
//   channel  signals                                        transfer when
//   in       in_valid in_ready kind delay_ms sem_id          in_valid && in_ready
//            sem_value
//   out      out_valid out_ready status new_task_id          out_valid && out_ready
//            running_task switched current_blocked
//   cfg      cfg_we cfg_index cfg_wdata                      cfg_we
//
// A tick passes through accept, cell update, chain search and output load; every other
// event goes from cell update straight to output load. The search runs as a token ripple
// down the task cell chain. Reset empties every task slot and clears all semaphore counts.
// A result waiting on out_ready holds the sequencer in its last step.
`default_nettype none

module round_robin_task_scheduler_unit
    import rrts_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          kind,
    input  wire logic [MS_W-1:0]     delay_ms,
    input  wire logic [SID_W-1:0]    sem_id,
    input  wire logic signed [7:0]   sem_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               status,
    output logic [TID_W-1:0]         new_task_id,
    output logic [TID_W-1:0]         running_task,
    output logic                     switched,
    output logic                     current_blocked,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [MS_W-1:0]     cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SRCH = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [MS_W-1:0]  min_dly_reg, max_dly_reg;
    logic [TID_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [7:0] sem_reg [NUM_SEMAPHORES];

    logic [2:0]        kind_reg;
    logic [MS_W-1:0]   dms_reg;
    logic [SID_W-1:0]  sid_reg;
    logic signed [7:0] sval_reg;

    logic [1:0]       res_status_reg, res_status_next;
    logic [TID_W-1:0] res_newid_reg, res_newid_next;
    logic             res_sw_reg, res_sw_next;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [TID_W-1:0] newid_reg;
    logic [TID_W-1:0] running_reg;
    logic             sw_reg;
    logic             blocked_reg;
    logic             load_out;

    logic                 sem_we;
    logic signed [7:0]    sem_wdata;
    logic signed [7:0]    sem_rd;
    logic signed [7:0]    sem_dec;
    logic signed [7:0]    sem_inc;
    logic [SEM_IDX_W-1:0] sid_idx;
    logic                 sid_ok;
    logic                 cur_valid;

    cell_cmd_t        cmd;
    cell_stat_t       cell_stat [MAX_TASKS];
    logic [MAX_TASKS:0] tok_a;
    logic [MAX_TASKS:0] tok_b;
    logic [TID_W-1:0] pos;

    assign in_ready  = state_reg == S_IDLE;
    assign cur_valid = CNT_W'(cur_reg) < count_reg;
    assign sid_ok    = 32'(sid_reg) < NUM_SEMAPHORES;
    assign sid_idx   = SEM_IDX_W'(sid_reg);
    assign sem_rd    = sem_reg[sid_idx];
    assign sem_dec   = (sem_rd == -8'sd128) ? sem_rd : sem_rd - 8'sd1;
    assign sem_inc   = (sem_rd == 8'sd127) ? sem_rd : sem_rd + 8'sd1;

    assign tok_a[0] = 1'b0;
    assign tok_b[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            rrts_task_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (TID_W'(gi)),
                .cmd       (cmd),
                .tok_a_in  (tok_a[gi]),
                .tok_b_in  (tok_b[gi]),
                .tok_a_out (tok_a[gi+1]),
                .tok_b_out (tok_b[gi+1]),
                .stat      (cell_stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (cell_stat[i].hit)
            begin
                pos = pos | TID_W'(i);
            end
        end
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_newid_next  = res_newid_reg;
        res_sw_next     = res_sw_reg;
        sem_we          = 1'b0;
        sem_wdata       = sem_rd;
        cmd.op          = OP_NONE;
        cmd.tid         = cur_reg;
        cmd.cur         = cur_reg;
        cmd.cur_valid   = cur_valid;
        cmd.count       = count_reg;
        cmd.dly         = dms_reg[MS_W-1:1];
        cmd.sem         = SEM_W'(sid_reg);
        cmd.found_a     = tok_a[MAX_TASKS];
        cmd.any_rdy     = tok_b[MAX_TASKS];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = RS_OK;
                res_newid_next  = '0;
                res_sw_next     = 1'b0;
                state_next      = S_DONE;
                unique case (kind_reg)
                    K_TICK:
                    begin
                        cmd.op     = OP_TICK;
                        state_next = S_SRCH;
                    end
                    K_CREATE:
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            res_status_next = RS_FULL;
                        end
                        else
                        begin
                            cmd.op         = OP_CREATE;
                            cmd.tid        = TID_W'(count_reg);
                            res_newid_next = TID_W'(count_reg);
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    K_DELAY:
                    begin
                        if (dms_reg > max_dly_reg || dms_reg < min_dly_reg)
                        begin
                            res_status_next = RS_RANGE;
                        end
                        else if (cur_valid)
                        begin
                            cmd.op = OP_DELAY;
                        end
                    end
                    K_WAIT:
                    begin
                        if (sid_ok)
                        begin
                            sem_we    = 1'b1;
                            sem_wdata = sem_dec;
                            if (sem_dec < 8'sd0 && cur_valid)
                            begin
                                cmd.op = OP_WAIT;
                            end
                        end
                    end
                    K_SIGNAL:
                    begin
                        if (sid_ok)
                        begin
                            sem_we    = 1'b1;
                            sem_wdata = sem_inc;
                            if (sem_inc <= 8'sd0)
                            begin
                                cmd.op = OP_SIGNAL;
                            end
                        end
                    end
                    K_SET:
                    begin
                        if (sid_ok)
                        begin
                            sem_we    = 1'b1;
                            sem_wdata = sval_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SRCH:
            begin
                cmd.op  = OP_PICK;
                cmd.tid = cur_valid ? cur_reg : '0;
                if (tok_b[MAX_TASKS])
                begin
                    cur_next    = pos;
                    res_sw_next = pos != cur_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            count_reg      <= '0;
            min_dly_reg    <= MIN_DELAY_RESET;
            max_dly_reg    <= MAX_DELAY_RESET;
            out_valid_reg  <= 1'b0;
            res_status_reg <= RS_OK;
            res_newid_reg  <= '0;
            res_sw_reg     <= 1'b0;
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                sem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_newid_reg  <= res_newid_next;
            res_sw_reg     <= res_sw_next;
            if (sem_we)
            begin
                sem_reg[sid_idx] <= sem_wdata;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_MIN_DELAY)
                begin
                    min_dly_reg <= cfg_wdata;
                end
                else if (cfg_index == REG_MAX_DELAY)
                begin
                    max_dly_reg <= cfg_wdata;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            dms_reg  <= delay_ms;
            sid_reg  <= sem_id;
            sval_reg <= sem_value;
        end
        if (load_out)
        begin
            status_reg  <= res_status_reg;
            newid_reg   <= res_newid_reg;
            running_reg <= cur_reg;
            sw_reg      <= res_sw_reg;
            blocked_reg <= cur_valid && (cell_stat[cur_reg].st == TS_BLOCKED);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign new_task_id     = newid_reg;
    assign running_task    = running_reg;
    assign switched        = sw_reg;
    assign current_blocked = blocked_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_task_cell.sv -----
// One task slot of the scheduler chain: state, delay counter, waited semaphore.
`default_nettype none

module rrts_task_cell
    import rrts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [TID_W-1:0] idx,
    input  wire cell_cmd_t        cmd,
    input  wire logic             tok_a_in,
    input  wire logic             tok_b_in,
    output logic                  tok_a_out,
    output logic                  tok_b_out,
    output cell_stat_t            stat
);

    task_st_t         st_reg, st_next;
    logic [DLY_W-1:0] dly_reg, dly_next;
    logic [SEM_W-1:0] wsem_reg, wsem_next;

    logic in_use;
    logic mine;
    logic cand_a;
    logic cand_b;
    logic hit;

    assign in_use = CNT_W'(idx) < cmd.count;
    assign mine   = idx == cmd.tid;

    always_comb
    begin
        cand_a = 1'b0;
        cand_b = in_use && (st_reg == TS_READY);
        if (cmd.op == OP_SIGNAL)
        begin
            cand_a = in_use && (st_reg == TS_BLOCKED) && (wsem_reg == cmd.sem);
        end
        else if (cmd.op == OP_PICK)
        begin
            cand_a = cand_b && (idx >= cmd.tid);
        end
    end

    assign tok_a_out = tok_a_in | cand_a;
    assign tok_b_out = tok_b_in | cand_b;

    always_comb
    begin
        hit = 1'b0;
        if (cmd.op == OP_SIGNAL)
        begin
            hit = cand_a && !tok_a_in;
        end
        else if (cmd.op == OP_PICK)
        begin
            hit = cmd.found_a ? (cand_a && !tok_a_in) : (cand_b && !tok_b_in);
        end
    end

    assign stat.st  = st_reg;
    assign stat.hit = hit;

    always_comb
    begin
        st_next   = st_reg;
        dly_next  = dly_reg;
        wsem_next = wsem_reg;
        unique case (cmd.op)
            OP_TICK:
            begin
                if (in_use && st_reg == TS_BLOCKED)
                begin
                    if (dly_reg == '0)
                    begin
                        if (wsem_reg == SEM_NONE)
                        begin
                            st_next = TS_READY;
                        end
                    end
                    else
                    begin
                        dly_next = dly_reg - DLY_W'(1);
                        if (dly_reg == DLY_W'(1))
                        begin
                            st_next = TS_READY;
                        end
                    end
                end
            end
            OP_CREATE:
            begin
                if (mine)
                begin
                    st_next   = TS_READY;
                    dly_next  = '0;
                    wsem_next = SEM_NONE;
                end
            end
            OP_DELAY:
            begin
                if (mine)
                begin
                    st_next  = TS_BLOCKED;
                    dly_next = cmd.dly;
                end
            end
            OP_WAIT:
            begin
                if (mine)
                begin
                    st_next   = TS_BLOCKED;
                    wsem_next = cmd.sem;
                end
            end
            OP_SIGNAL:
            begin
                if (hit)
                begin
                    st_next   = TS_READY;
                    wsem_next = SEM_NONE;
                end
            end
            OP_PICK:
            begin
                if (hit)
                begin
                    st_next = TS_RUNNING;
                end
                else if (cmd.any_rdy && cmd.cur_valid && (idx == cmd.cur)
                         && st_reg == TS_RUNNING)
                begin
                    st_next = TS_READY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= TS_EMPTY;
            dly_reg  <= '0;
            wsem_reg <= SEM_NONE;
        end
        else
        begin
            st_reg   <= st_next;
            dly_reg  <= dly_next;
            wsem_reg <= wsem_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_round_robin_task_scheduler_unit.sv -----
// Self-checking testbench for the round-robin task scheduler unit.
`timescale 1ns / 100ps

module tb_round_robin_task_scheduler_unit;
    import rrts_pkg::*;

    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;
    localparam logic signed [7:0] SEM_FLOOR = 8'sh80;
    localparam logic signed [7:0] SEM_CEIL  = 8'sh7F;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        logic [1:0]       status;
        logic [TID_W-1:0] new_id;
        logic [TID_W-1:0] running;
        logic             switched;
        logic             blocked;
    } sched_res_t;

    typedef struct {
        logic [2:0]        kind;
        logic [MS_W-1:0]   dms;
        logic [SID_W-1:0]  sid;
        logic signed [7:0] sval;
        bit                typed;
        sched_res_t        want;
    } stim_row_t;

    localparam sched_res_t RES_QUIET = '0;
    localparam sched_res_t RES_RANGE = '{RS_RANGE, 3'd0, 3'd0, 1'b0, 1'b0};
    localparam sched_res_t RES_FULL  = '{RS_FULL, 3'd0, 3'd0, 1'b0, 1'b0};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            kind;
    logic [MS_W-1:0]       delay_ms;
    logic [SID_W-1:0]      sem_id;
    logic signed [7:0]     sem_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [TID_W-1:0]      new_task_id;
    logic [TID_W-1:0]      running_task;
    logic                  switched;
    logic                  current_blocked;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [MS_W-1:0]       cfg_wdata;

    task_st_t              slot_st   [MAX_TASKS];
    logic [DLY_W-1:0]      slot_dly  [MAX_TASKS];
    logic [SEM_W-1:0]      slot_wsem [MAX_TASKS];
    logic signed [7:0]     sem_cnt   [NUM_SEMAPHORES];
    int                    task_total;
    int                    cur_tid;
    logic [MS_W-1:0]       min_ms;
    logic [MS_W-1:0]       max_ms;

    sched_res_t            pending_res [$];
    sched_res_t            next_res;
    sched_res_t            got_res;
    sched_res_t            row_want;
    bit                    row_typed;
    bit                    calm;
    int                    err_cnt;
    int                    cycles;
    stim_row_t             opening_rows [27];

    round_robin_task_scheduler_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .delay_ms        (delay_ms),
        .sem_id          (sem_id),
        .sem_value       (sem_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .new_task_id     (new_task_id),
        .running_task    (running_task),
        .switched        (switched),
        .current_blocked (current_blocked),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic sched_res_t schedule_event(logic [2:0] k, logic [MS_W-1:0] dms,
                                                  logic [SID_W-1:0] sid,
                                                  logic signed [7:0] sval);
        sched_res_t r;
        int         i;
        int         pos;
        bit         any;
        bit         hit;
        r = '0;
        case (k)
            K_TICK:
            begin
                for (i = 0; i < task_total; i++)
                begin
                    if (slot_st[i] == TS_BLOCKED)
                    begin
                        if (slot_dly[i] == '0)
                        begin
                            if (slot_wsem[i] == SEM_NONE)
                                slot_st[i] = TS_READY;
                        end
                        else
                        begin
                            slot_dly[i] = slot_dly[i] - 1'b1;
                            if (slot_dly[i] == '0)
                                slot_st[i] = TS_READY;
                        end
                    end
                end
                any = 1'b0;
                for (i = 0; i < task_total; i++)
                    if (slot_st[i] == TS_READY)
                        any = 1'b1;
                if (any)
                begin
                    pos = (cur_tid < task_total) ? cur_tid : 0;
                    hit = 1'b0;
                    for (i = 0; i < task_total && !hit; i++)
                    begin
                        if (slot_st[pos] == TS_READY)
                            hit = 1'b1;
                        else
                        begin
                            pos++;
                            if (pos >= task_total)
                                pos = 0;
                        end
                    end
                    if (cur_tid < task_total && slot_st[cur_tid] == TS_RUNNING)
                        slot_st[cur_tid] = TS_READY;
                    r.switched = (pos != cur_tid);
                    cur_tid = pos;
                    slot_st[pos] = TS_RUNNING;
                end
            end
            K_CREATE:
            begin
                if (task_total >= MAX_TASKS)
                    r.status = RS_FULL;
                else
                begin
                    r.new_id = TID_W'(task_total);
                    slot_st[task_total] = TS_READY;
                    slot_dly[task_total] = '0;
                    slot_wsem[task_total] = SEM_NONE;
                    task_total++;
                end
            end
            K_DELAY:
            begin
                if (dms > max_ms || dms < min_ms)
                    r.status = RS_RANGE;
                else if (cur_tid < task_total)
                begin
                    slot_dly[cur_tid] = dms[MS_W-1:1];
                    slot_st[cur_tid] = TS_BLOCKED;
                end
            end
            K_WAIT:
            begin
                if (int'(sid) < NUM_SEMAPHORES)
                begin
                    if (sem_cnt[sid] != SEM_FLOOR)
                        sem_cnt[sid] = sem_cnt[sid] - 8'sd1;
                    if (sem_cnt[sid] < 0 && cur_tid < task_total)
                    begin
                        slot_wsem[cur_tid] = SEM_W'(sid);
                        slot_st[cur_tid] = TS_BLOCKED;
                    end
                end
            end
            K_SIGNAL:
            begin
                if (int'(sid) < NUM_SEMAPHORES)
                begin
                    if (sem_cnt[sid] != SEM_CEIL)
                        sem_cnt[sid] = sem_cnt[sid] + 8'sd1;
                    if (sem_cnt[sid] <= 0)
                    begin
                        hit = 1'b0;
                        for (i = 0; i < task_total && !hit; i++)
                        begin
                            if (slot_st[i] == TS_BLOCKED && slot_wsem[i] == SEM_W'(sid))
                            begin
                                slot_st[i] = TS_READY;
                                slot_wsem[i] = SEM_NONE;
                                hit = 1'b1;
                            end
                        end
                    end
                end
            end
            K_SET:
            begin
                if (int'(sid) < NUM_SEMAPHORES)
                    sem_cnt[sid] = sval;
            end
            default:
            begin
            end
        endcase
        r.running = TID_W'(cur_tid);
        r.blocked = (cur_tid < task_total) && (slot_st[cur_tid] == TS_BLOCKED);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic push_event(logic [2:0] k, logic [MS_W-1:0] dms, logic [SID_W-1:0] sid,
                              logic signed [7:0] sval, bit typed, sched_res_t want);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 11)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        delay_ms  <= dms;
        sem_id    <= sid;
        sem_value <= sval;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_burst(int n);
        int                sel;
        int                span;
        logic [2:0]        k;
        logic [MS_W-1:0]   d;
        logic [SID_W-1:0]  s;
        logic signed [7:0] v;
        for (int j = 0; j < n; j++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 34)
                k = K_TICK;
            else if (sel < 39)
                k = K_CREATE;
            else if (sel < 54)
                k = K_DELAY;
            else if (sel < 69)
                k = K_WAIT;
            else if (sel < 84)
                k = K_SIGNAL;
            else if (sel < 95)
                k = K_SET;
            else
                k = ($urandom_range(0, 1) == 0) ? K_SPARE6 : K_SPARE7;
            sel = $urandom_range(0, 99);
            if (sel < 3)
                d = MS_W'($urandom());
            else if (sel < 20)
                d = MS_W'($urandom_range(0, 8));
            else
            begin
                span = int'(min_ms) + int'($urandom_range(0, 12));
                d = (span > 65535) ? '1 : MS_W'(span);
            end
            s = SID_W'($urandom_range(0, NUM_SEMAPHORES - 1));
            if ($urandom_range(0, 9) == 0)
                v = 8'($urandom());
            else
                v = 8'(int'($urandom_range(0, 6)) - 3);
            push_event(k, d, s, v, 1'b0, RES_QUIET);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_delays(logic [MS_W-1:0] lo, logic [MS_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_DELAY;
        cfg_wdata <= lo;
        min_ms = lo;
        @(negedge clk);
        cfg_index <= REG_MAX_DELAY;
        cfg_wdata <= hi;
        max_ms = hi;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            next_res = schedule_event(kind, delay_ms, sem_id, sem_value);
            pending_res.push_back(row_typed ? row_want : next_res);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_res.size() == 0)
                report_mismatch("result with nothing pending");
            else
            begin
                got_res = pending_res.pop_front();
                check_field("status", status, got_res.status);
                check_field("new_task_id", new_task_id, got_res.new_id);
                check_field("running_task", running_task, got_res.running);
                check_field("switched", switched, got_res.switched);
                check_field("current_blocked", current_blocked, got_res.blocked);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    initial
    begin
        logic [MS_W-1:0] lo;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= K_TICK;
        delay_ms  <= '0;
        sem_id    <= '0;
        sem_value <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MIN_DELAY;
        cfg_wdata <= '0;
        row_typed <= 1'b0;
        row_want  <= RES_QUIET;
        cycles    <= 0;
        calm = 1'b0;
        err_cnt = 0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            slot_st[i]   = TS_EMPTY;
            slot_dly[i]  = '0;
            slot_wsem[i] = SEM_NONE;
        end
        for (int i = 0; i < NUM_SEMAPHORES; i++)
            sem_cnt[i] = '0;
        task_total = 0;
        cur_tid    = 0;
        min_ms     = MIN_DELAY_RESET;
        max_ms     = MAX_DELAY_RESET;

        opening_rows = '{
            '{K_TICK,     16'd0,     3'd0, 8'sh00, 1'b1, RES_QUIET},
            '{K_DELAY,    16'd0,     3'd0, 8'sh00, 1'b1, RES_RANGE},
            '{K_DELAY,    16'hFFFF,  3'd0, 8'sh00, 1'b1, RES_RANGE},
            '{K_DELAY,    16'd60001, 3'd0, 8'sh00, 1'b1, RES_RANGE},
            '{K_DELAY,    16'd2,     3'd0, 8'sh00, 1'b1, RES_QUIET},
            '{K_WAIT,     16'd0,     3'd0, 8'sh00, 1'b1, RES_QUIET},
            '{K_SIGNAL,   16'd0,     3'd0, 8'sh00, 1'b1, RES_QUIET},
            '{K_SET,      16'd0,     3'd7, 8'sh80, 1'b1, RES_QUIET},
            '{K_WAIT,     16'd0,     3'd7, 8'sh00, 1'b1, RES_QUIET},
            '{K_SET,      16'd0,     3'd6, 8'sh7F, 1'b1, RES_QUIET},
            '{K_SIGNAL,   16'd0,     3'd6, 8'sh00, 1'b1, RES_QUIET},
            '{K_SPARE6,   16'd0,     3'd0, 8'sh00, 1'b1, RES_QUIET},
            '{K_SPARE7,   16'hFFFF,  3'd7, 8'shFF, 1'b1, RES_QUIET},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd0, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd1, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd2, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd3, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd4, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd5, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd6, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, '{RS_OK, 3'd7, 3'd0, 1'b0, 1'b0}},
            '{K_CREATE,   16'd0,     3'd0, 8'sh00, 1'b1, RES_FULL},
            '{K_TICK,     16'd0,     3'd0, 8'sh00, 1'b0, RES_QUIET},
            '{K_WAIT,     16'd0,     3'd7, 8'sh00, 1'b0, RES_QUIET},
            '{K_TICK,     16'd0,     3'd0, 8'sh00, 1'b0, RES_QUIET},
            '{K_DELAY,    16'd3,     3'd0, 8'sh00, 1'b0, RES_QUIET},
            '{K_TICK,     16'd0,     3'd0, 8'sh00, 1'b0, RES_QUIET}
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_rows[i])
            push_event(opening_rows[i].kind, opening_rows[i].dms, opening_rows[i].sid,
                       opening_rows[i].sval, opening_rows[i].typed, opening_rows[i].want);

        settle();
        program_delays(16'd0, 16'hFFFF);
        random_burst(450);

        settle();
        program_delays(16'hFFFF, 16'd0);
        calm = 1'b1;
        random_burst(120);
        calm = 1'b0;

        settle();
        program_delays(16'd0, 16'd3);
        random_burst(350);

        settle();
        lo = MS_W'($urandom_range(0, 40));
        program_delays(lo, lo + MS_W'($urandom_range(0, 100)));
        random_burst(400);

        settle();
        program_delays(MIN_DELAY_RESET, MAX_DELAY_RESET);
        calm = 1'b1;
        random_burst(300);

        settle();
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_task_cell.sv
hw/rtl/round_robin_task_scheduler_unit.sv
tb/sv/tb_round_robin_task_scheduler_unit.sv
